@@ hdl/nnsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared types and constants for the nearest-neighbor scaling address block.
// ----------------------------------------------------------------------------
`default_nettype none

package nnsa_pkg;

	// Field widths fixed by the interface
	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int PB_W    = 3;
	localparam int BASE_W  = 32;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 32;
	localparam int OUT_AW  = 32;

	// Scaled coordinate: coordinate times dimension
	localparam int NUM_W = COORD_W + DIM_W;
	// Linear pixel index and byte offset
	localparam int LIN_W = 2 * DIM_W + 1;
	localparam int OFF_W = LIN_W + PB_W;

	localparam logic [PB_W-1:0] PB_MIN = PB_W'(3);
	localparam logic [PB_W-1:0] PB_MAX = PB_W'(4);

	// Configuration register indexes
	typedef enum logic [CFG_IW-1:0] {
		REG_SRC_BASE  = 3'd0,
		REG_DST_BASE  = 3'd1,
		REG_SRC_WIDTH = 3'd2,
		REG_SRC_HEIGHT = 3'd3,
		REG_DST_WIDTH = 3'd4,
		REG_DST_HEIGHT = 3'd5,
		REG_SRC_PB    = 3'd6,
		REG_DST_PB    = 3'd7
	} cfg_reg_t;

	// Clamp a pixel byte count to 3 or 4
	function automatic logic [PB_W-1:0] clamp_pb(input logic [PB_W-1:0] v);
		logic [PB_W-1:0] r;
		r = v;
		if (v < PB_MIN)
			r = PB_MIN;
		else if (v > PB_MAX)
			r = PB_MAX;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/nnsa_div.sv @@
// ----------------------------------------------------------------------------
// nnsa_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nnsa_div (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [nnsa_pkg::NUM_W-1:0]  num,
	input  wire logic [nnsa_pkg::DIM_W-1:0]  den,
	output logic      [nnsa_pkg::NUM_W-1:0]  quo,
	output logic      [nnsa_pkg::DIM_W-1:0]  rem
);
	import nnsa_pkg::*;

	logic [NUM_W-1:0] num_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [DIM_W-1:0] rem_s [NUM_W];

	// One stage per quotient bit, most significant first
	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic [NUM_W-1:0] num_prev;
		logic [NUM_W-1:0] quo_prev;
		logic [DIM_W-1:0] rem_prev;
		logic [DIM_W:0]   trial;
		logic             ge;

		if (g == 0) begin : g_first
			assign num_prev = num;
			assign quo_prev = '0;
			assign rem_prev = '0;
		end else begin : g_next
			assign num_prev = num_s[g-1];
			assign quo_prev = quo_s[g-1];
			assign rem_prev = rem_s[g-1];
		end

		assign trial = {rem_prev, num_prev[NUM_W-1-g]};
		assign ge    = trial >= {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[g] <= num_prev;
				quo_s[g] <= {quo_prev[NUM_W-2:0], ge};
				rem_s[g] <= ge ? DIM_W'(trial - {1'b0, den}) : trial[DIM_W-1:0];
			end
		end
	end

	assign quo = quo_s[NUM_W-1];
	assign rem = rem_s[NUM_W-1];

endmodule

`default_nettype wire

@@ hdl/nnsa_round.sv @@
// ----------------------------------------------------------------------------
// nnsa_round
// Rounds a quotient up when the remainder exceeds half the divisor, then
// clamps it to the last source index.
// ----------------------------------------------------------------------------
`default_nettype none

module nnsa_round (
	input  wire logic [nnsa_pkg::NUM_W-1:0] quo,
	input  wire logic [nnsa_pkg::DIM_W-1:0] rem,
	input  wire logic [nnsa_pkg::DIM_W-1:0] den,
	input  wire logic [nnsa_pkg::DIM_W-1:0] lim,
	output logic      [nnsa_pkg::DIM_W-1:0] idx
);
	import nnsa_pkg::*;

	logic [NUM_W:0] q_up;

	// Round on a strict half, then clamp to lim - 1
	always_comb begin
		q_up = {1'b0, quo} + ((({rem, 1'b0}) > {1'b0, den}) ? (NUM_W+1)'(1) : '0);
		if (q_up >= (NUM_W+1)'(lim))
			idx = lim - DIM_W'(1);
		else
			idx = q_up[DIM_W-1:0];
	end

endmodule

`default_nettype wire

@@ hdl/nearest_neighbor_scale_addr.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addr
// Source and destination address generator for nearest-neighbor scaling.
// ----------------------------------------------------------------------------
// Accepts one destination coordinate per clock while the output is not
// stalled, and returns one result per item, in order, after NUM_W + 4 = 29
// register stages. Most stages sit in the two bit-serial divider pipelines
// (one quotient bit per stage) that
// map row and column; a multiply stage in front and a round, an index
// multiply and an address stage behind them make up the rest. A stall at the
// output freezes the whole pipeline. Configuration is read live by every
// stage, so write it only while no item is in flight.
`default_nettype none

module nearest_neighbor_scale_addr #(
	parameter int MAX_DIM    = 4096,
	parameter int ADDR_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [nnsa_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [nnsa_pkg::CFG_DW-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [nnsa_pkg::COORD_W-1:0]  dest_row,
	input  wire logic [nnsa_pkg::COORD_W-1:0]  dest_col,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [nnsa_pkg::COORD_W-1:0]  src_row,
	output logic      [nnsa_pkg::COORD_W-1:0]  src_col,
	output logic      [nnsa_pkg::OUT_AW-1:0]   src_addr,
	output logic      [nnsa_pkg::OUT_AW-1:0]   dst_addr,
	output logic                               zero_fourth_byte,
	output logic                               in_range
);
	import nnsa_pkg::*;

	localparam int CW = (ADDR_WIDTH > OUT_AW) ? ADDR_WIDTH : OUT_AW;
	localparam logic [DIM_W-1:0] DIM_LIM =
		(MAX_DIM >= (1 << DIM_W)) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

	// Configuration registers
	logic [BASE_W-1:0] src_base_q, dst_base_q;
	logic [DIM_W-1:0]  src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [PB_W-1:0]   src_pb_q, dst_pb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= '0;
			dst_base_q <= '0;
			src_w_q    <= DIM_W'(640);
			src_h_q    <= DIM_W'(480);
			dst_w_q    <= DIM_W'(640);
			dst_h_q    <= DIM_W'(480);
			src_pb_q   <= PB_W'(3);
			dst_pb_q   <= PB_W'(3);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_BASE:   src_base_q <= cfg_data[BASE_W-1:0];
				REG_DST_BASE:   dst_base_q <= cfg_data[BASE_W-1:0];
				REG_SRC_WIDTH:  src_w_q    <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT: src_h_q    <= cfg_data[DIM_W-1:0];
				REG_DST_WIDTH:  dst_w_q    <= cfg_data[DIM_W-1:0];
				REG_DST_HEIGHT: dst_h_q    <= cfg_data[DIM_W-1:0];
				REG_SRC_PB:     src_pb_q   <= cfg_data[PB_W-1:0];
				REG_DST_PB:     dst_pb_q   <= cfg_data[PB_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective dimensions and byte counts
	logic [DIM_W-1:0] sw, sh, dw, dh;
	logic [PB_W-1:0]  spb, dpb;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_LIM)
			r = DIM_LIM;
		return r;
	endfunction

	assign sw  = clamp_dim(src_w_q);
	assign sh  = clamp_dim(src_h_q);
	assign dw  = clamp_dim(dst_w_q);
	assign dh  = clamp_dim(dst_h_q);
	assign spb = clamp_pb(src_pb_q);
	assign dpb = clamp_pb(dst_pb_q);

	// Whole pipeline advances when the output register is free or taken
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: scale coordinates, linear destination index, range check
	logic             v_s1;
	logic [NUM_W-1:0] rnum_s1, cnum_s1;
	logic [LIN_W-1:0] dlin_s1;
	logic             inr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnum_s1 <= NUM_W'(dest_row) * NUM_W'(sh);
			cnum_s1 <= NUM_W'(dest_col) * NUM_W'(sw);
			dlin_s1 <= LIN_W'(dest_row) * LIN_W'(dw) + LIN_W'(dest_col);
			inr_s1  <= ({1'b0, dest_row} < dh) && ({1'b0, dest_col} < dw);
		end
	end

	// Divider stages
	logic [NUM_W-1:0] rquo, cquo;
	logic [DIM_W-1:0] rrem, crem;

	nnsa_div u_div_row (
		.clk (clk), .en (en), .num (rnum_s1), .den (dh), .quo (rquo), .rem (rrem)
	);

	nnsa_div u_div_col (
		.clk (clk), .en (en), .num (cnum_s1), .den (dw), .quo (cquo), .rem (crem)
	);

	// Sideband that travels alongside the dividers
	logic             v_sd   [NUM_W];
	logic [LIN_W-1:0] dlin_sd[NUM_W];
	logic             inr_sd [NUM_W];

	for (genvar g = 0; g < NUM_W; g++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sd[g] <= 1'b0;
			else if (en)
				v_sd[g] <= (g == 0) ? v_s1 : v_sd[(g == 0) ? 0 : g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dlin_sd[g] <= (g == 0) ? dlin_s1 : dlin_sd[(g == 0) ? 0 : g-1];
				inr_sd[g]  <= (g == 0) ? inr_s1  : inr_sd[(g == 0) ? 0 : g-1];
			end
		end
	end

	// Round stage
	logic [DIM_W-1:0] srow_c, scol_c;

	nnsa_round u_rnd_row (.quo (rquo), .rem (rrem), .den (dh), .lim (sh), .idx (srow_c));
	nnsa_round u_rnd_col (.quo (cquo), .rem (crem), .den (dw), .lim (sw), .idx (scol_c));

	logic             v_s2, inr_s2;
	logic [DIM_W-1:0] srow_s2, scol_s2;
	logic [LIN_W-1:0] dlin_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_sd[NUM_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srow_s2 <= srow_c;
			scol_s2 <= scol_c;
			dlin_s2 <= dlin_sd[NUM_W-1];
			inr_s2  <= inr_sd[NUM_W-1];
		end
	end

	// Index stage: linear source index
	logic             v_s3, inr_s3;
	logic [DIM_W-1:0] srow_s3, scol_s3;
	logic [LIN_W-1:0] slin_s3, dlin_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srow_s3 <= srow_s2;
			scol_s3 <= scol_s2;
			slin_s3 <= LIN_W'(srow_s2) * LIN_W'(sw) + LIN_W'(scol_s2);
			dlin_s3 <= dlin_s2;
			inr_s3  <= inr_s2;
		end
	end

	// Address stage: scale by pixel size, add base, wrap
	logic [CW-1:0]         saddr_full, daddr_full;
	logic [ADDR_WIDTH-1:0] saddr_w, daddr_w;
	logic [CW-1:0]         saddr_x, daddr_x;

	assign saddr_full = CW'(src_base_q) + CW'(OFF_W'(slin_s3) * OFF_W'(spb));
	assign daddr_full = CW'(dst_base_q) + CW'(OFF_W'(dlin_s3) * OFF_W'(dpb));
	assign saddr_w    = saddr_full[ADDR_WIDTH-1:0];
	assign daddr_w    = daddr_full[ADDR_WIDTH-1:0];
	assign saddr_x    = CW'(saddr_w);
	assign daddr_x    = CW'(daddr_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_row          <= srow_s3[COORD_W-1:0];
			src_col          <= scol_s3[COORD_W-1:0];
			src_addr         <= saddr_x[OUT_AW-1:0];
			dst_addr         <= daddr_x[OUT_AW-1:0];
			zero_fourth_byte <= (dpb == PB_MAX);
			in_range         <= inr_s3;
		end
	end

endmodule

`default_nettype wire

@@ hdl/nnsa_checker.sv @@
// ----------------------------------------------------------------------------
// nnsa_checker
// Port-level assertions for the nearest-neighbor scaling address block.
// ----------------------------------------------------------------------------
`default_nettype none

module nnsa_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [nnsa_pkg::OUT_AW-1:0]   src_addr,
	input wire logic [nnsa_pkg::OUT_AW-1:0]   dst_addr,
	input wire logic [nnsa_pkg::COORD_W-1:0]  src_row,
	input wire logic [nnsa_pkg::COORD_W-1:0]  src_col
);
	// A held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(src_addr) && $stable(dst_addr)
			&& $stable(src_row) && $stable(src_col))
		else $error("result changed while stalled");

	// Input side stalls exactly when the output is blocked
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output space");

	// A new result only appears after the pipeline advanced
	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared while pipeline frozen");

	// A stalled output blocks new input transfers
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(in_valid && in_ready))
		else $error("input taken during output stall");

endmodule

bind nearest_neighbor_scale_addr nnsa_checker u_nnsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.src_addr  (src_addr),
	.dst_addr  (dst_addr),
	.src_row   (src_row),
	.src_col   (src_col)
);

`default_nettype wire

@@ tb/nnsa_checker.sv @@
// ----------------------------------------------------------------------------
// nnsa_scoreboard
// Watches the coordinate and address channels of the scaling address block,
// works out the source mapping and both byte addresses for every accepted
// coordinate, and compares each returned result with the oldest one pending.
// ----------------------------------------------------------------------------
module nnsa_scoreboard (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [nnsa_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [nnsa_pkg::CFG_DW-1:0]       cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [nnsa_pkg::COORD_W-1:0]      dest_row,
	input  logic [nnsa_pkg::COORD_W-1:0]      dest_col,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [nnsa_pkg::COORD_W-1:0]      src_row,
	input  logic [nnsa_pkg::COORD_W-1:0]      src_col,
	input  logic [nnsa_pkg::OUT_AW-1:0]       src_addr,
	input  logic [nnsa_pkg::OUT_AW-1:0]       dst_addr,
	input  logic                              zero_fourth_byte,
	input  logic                              in_range,
	output int                                fail_count,
	output int                                pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import nnsa_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] srow;
		logic [COORD_W-1:0] scol;
		logic [31:0]        saddr;
		logic [31:0]        daddr;
		logic               zfb;
		logic               inr;
	} addr_result_t;

	addr_result_t pending_addrs[$];

	logic [31:0]      src_base_q, dst_base_q;
	logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [PB_W-1:0]  src_pb_q, dst_pb_q;

	function automatic longint unsigned dim_used(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > 4096) return 4096;
		return v;
	endfunction

	function automatic longint unsigned bytes_used(input logic [PB_W-1:0] v);
		if (v < 3) return 3;
		if (v > 4) return 4;
		return v;
	endfunction

	// Rounded quotient d*s/den, ties go down, clamped to s-1
	function automatic longint unsigned nearest_src(input longint unsigned d,
			input longint unsigned s, input longint unsigned den);
		longint unsigned num, q, r;
		num = d * s;
		q = num / den;
		r = num % den;
		if (2 * r > den) q++;
		if (q >= s) q = s - 1;
		return q;
	endfunction

	function automatic addr_result_t map_coord(input logic [COORD_W-1:0] row,
			input logic [COORD_W-1:0] col);
		addr_result_t res;
		longint unsigned sw, sh, dw, dh, spb, dpb, sr, sc;
		sw = dim_used(src_w_q);
		sh = dim_used(src_h_q);
		dw = dim_used(dst_w_q);
		dh = dim_used(dst_h_q);
		spb = bytes_used(src_pb_q);
		dpb = bytes_used(dst_pb_q);
		sr = nearest_src(row, sh, dh);
		sc = nearest_src(col, sw, dw);
		res.srow = sr[COORD_W-1:0];
		res.scol = sc[COORD_W-1:0];
		res.saddr = 32'(src_base_q + (sr * sw + sc) * spb);
		res.daddr = 32'(dst_base_q + (longint'(row) * dw + col) * dpb);
		res.zfb = (dpb == 4);
		res.inr = (row < dh) && (col < dw);
		return res;
	endfunction

	assign pending_count = pending_addrs.size();

	// Track registers, predict on input transfer, compare on output transfer
	always @(posedge clk or negedge arst_n) begin
		addr_result_t got, want;
		if (!arst_n) begin
			src_base_q <= 0;
			dst_base_q <= 0;
			src_w_q <= 640;
			src_h_q <= 480;
			dst_w_q <= 640;
			dst_h_q <= 480;
			src_pb_q <= 3;
			dst_pb_q <= 3;
			fail_count <= 0;
			pending_addrs.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_SRC_BASE:   src_base_q <= cfg_data;
					REG_DST_BASE:   dst_base_q <= cfg_data;
					REG_SRC_WIDTH:  src_w_q <= cfg_data[DIM_W-1:0];
					REG_SRC_HEIGHT: src_h_q <= cfg_data[DIM_W-1:0];
					REG_DST_WIDTH:  dst_w_q <= cfg_data[DIM_W-1:0];
					REG_DST_HEIGHT: dst_h_q <= cfg_data[DIM_W-1:0];
					REG_SRC_PB:     src_pb_q <= cfg_data[PB_W-1:0];
					REG_DST_PB:     dst_pb_q <= cfg_data[PB_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_addrs.push_back(map_coord(dest_row, dest_col));
			if (out_valid && out_ready) begin
				got = '{src_row, src_col, src_addr, dst_addr, zero_fourth_byte, in_range};
				if (pending_addrs.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_addrs.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display({"mismatch: exp row %0d col %0d sa %h da %h z %b r %b",
								" / got row %0d col %0d sa %h da %h z %b r %b"},
								want.srow, want.scol, want.saddr, want.daddr,
								want.zfb, want.inr,
								got.srow, got.scol, got.saddr, got.daddr,
								got.zfb, got.inr);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives coordinates and register settings into the scaling address block
// under several idle patterns and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nnsa_pkg::*;

	localparam int LATENCY = 40;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [COORD_W-1:0] dest_row = '0, dest_col = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [COORD_W-1:0] src_row, src_col;
	logic [OUT_AW-1:0] src_addr, dst_addr;
	logic zero_fourth_byte, in_range;
	int fail_count, pending_count;
	int send_idle_pct = 0, stall_pct = 0;
	longint cycle_count = 0;
	logic [DIM_W-1:0] cur_dw = 640, cur_dh = 480;

	nearest_neighbor_scale_addr DUT (.*);

	nnsa_scoreboard checker_i (.*);

	initial forever #1 clk = ~clk;

	// Receiver: stall at random
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// Guard against a hang
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** nearest_neighbor_scale_addr: FAILED **");
			$finish;
		end
	end

	// Hold the write enable high across a run of writes
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_DST_WIDTH) cur_dw = val[DIM_W-1:0];
		if (idx == REG_DST_HEIGHT) cur_dh = val[DIM_W-1:0];
	endtask

	task automatic end_writes();
		cfg_wr_en <= 0;
	endtask

	// One coordinate transfer, with a random idle gap first
	task automatic send_coord(input logic [11:0] row, input logic [11:0] col);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		dest_row <= row;
		dest_col <= col;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [12:0] rand_dim();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'(4096 + $urandom_range(4095));
			2: return 13'($urandom_range(1, 16));
			3: return 13'd4096;
			default: return 13'($urandom_range(1, 4096));
		endcase
	endfunction

	// Coordinate mostly inside the destination image
	function automatic logic [11:0] rand_coord(input logic [12:0] lim);
		int l;
		l = (lim == 0) ? 1 : (lim > 4096 ? 4096 : lim);
		if ($urandom_range(9) == 0) return 12'($urandom);
		return 12'($urandom_range(l - 1));
	endfunction

	task automatic random_setting();
		write_reg(REG_SRC_BASE, $urandom);
		write_reg(REG_DST_BASE, $urandom);
		write_reg(REG_SRC_WIDTH, rand_dim());
		write_reg(REG_SRC_HEIGHT, rand_dim());
		write_reg(REG_DST_WIDTH, rand_dim());
		write_reg(REG_DST_HEIGHT, rand_dim());
		write_reg(REG_SRC_PB, $urandom_range(7));
		write_reg(REG_DST_PB, $urandom_range(7));
		end_writes();
	endtask

	initial begin
		int phase;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset setting, field extremes, rounding ties, out of range
		send_coord(0, 0);
		send_coord(479, 639);
		send_coord(480, 640);
		send_coord(12'hFFF, 12'hFFF);
		send_coord(12'hAAA, 12'h555);
		drain();
		write_reg(REG_SRC_BASE, 32'hFFFF_FFF0);
		write_reg(REG_DST_BASE, 32'hFFFF_FFFF);
		write_reg(REG_SRC_WIDTH, 3);
		write_reg(REG_SRC_HEIGHT, 1);
		write_reg(REG_DST_WIDTH, 2);
		write_reg(REG_DST_HEIGHT, 4);
		write_reg(REG_SRC_PB, 0);
		write_reg(REG_DST_PB, 7);
		end_writes();
		for (int i = 0; i < 5; i++) send_coord(12'(i), 12'(i));
		send_coord(12'hFFF, 0);
		drain();
		write_reg(REG_SRC_WIDTH, 4096);
		write_reg(REG_SRC_HEIGHT, 13'h1FFF);
		write_reg(REG_DST_WIDTH, 0);
		write_reg(REG_DST_HEIGHT, 4096);
		write_reg(REG_SRC_PB, 4);
		write_reg(REG_DST_PB, 3);
		end_writes();
		send_coord(0, 0);
		send_coord(4095, 4095);
		send_coord(2048, 1);
		drain();
		write_reg(REG_SRC_WIDTH, 5);
		write_reg(REG_DST_WIDTH, 2);
		write_reg(REG_SRC_PB, 2);
		write_reg(REG_DST_PB, 4);
		end_writes();
		send_coord(1, 1);
		send_coord(0, 2);
		drain();

		// Random: idle patterns per phase, new setting each sub-block
		for (phase = 0; phase < 12; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 48; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 48; end
				default: begin send_idle_pct = 27; stall_pct = 27; end
			endcase
			random_setting();
			for (int i = 0; i < 150; i++)
				send_coord(rand_coord(cur_dh), rand_coord(cur_dw));
			drain();
		end
		stall_pct = 0;
		drain();

		if (fail_count == 0)
			$display("** nearest_neighbor_scale_addr: PASSED **");
		else
			$display("** nearest_neighbor_scale_addr: FAILED **");
		$finish;
	end
endmodule
